// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define SWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition in this cycle implies consequence in the same cycle.
`define SWS_ASSERT_NOW(label, trig, cons, msg) \
  `SWS_ASSERT(label, (trig) |-> (cons), msg)

// Condition in this cycle implies consequence in the next cycle.
`define SWS_ASSERT_NEXT(label, trig, cons, msg) \
  `SWS_ASSERT(label, (trig) |=> (cons), msg)

`endif

// ===== design/sws_pkg.sv =====
// Shared types and constants of the sliding window sender.
package sws_pkg;

  localparam int MAX_WINDOW_DEF   = 16;
  localparam int SEQ_BITS_DEF     = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int CMD_BITS  = 2;
  localparam int KIND_BITS = 2;
  localparam int CFG_BITS  = 5;

  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_OFFER = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_NACK  = 2'd2
  } cmd_e;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_NONE   = 2'd0,
    KIND_NEW    = 2'd1,
    KIND_RESEND = 2'd2
  } kind_e;

endpackage

// ===== design/sws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sws_ctrl.sv =====
// Window controller: base and next pointers, acknowledge marks, command sequencing.
module sws_ctrl #(
  parameter int MAX_WINDOW   = sws_pkg::MAX_WINDOW_DEF,
  parameter int SEQ_BITS     = sws_pkg::SEQ_BITS_DEF,
  parameter int PAYLOAD_BITS = sws_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [sws_pkg::CMD_BITS-1:0]    cmd_i,
  input  logic [SEQ_BITS-1:0]             ack_seq_i,
  input  logic [PAYLOAD_BITS-1:0]         payload_i,
  input  logic [$clog2(MAX_WINDOW):0]     eff_win_i,
  output logic                            ram_we_o,
  output logic [$clog2(MAX_WINDOW)-1:0]   ram_waddr_o,
  output logic [PAYLOAD_BITS-1:0]         ram_wdata_o,
  output logic                            ram_re_o,
  output logic [$clog2(MAX_WINDOW)-1:0]   ram_raddr_o,
  input  logic [PAYLOAD_BITS-1:0]         ram_rdata_i,
  output logic                            done_o,
  output logic [sws_pkg::KIND_BITS-1:0]   send_kind_o,
  output logic [SEQ_BITS-1:0]             send_seq_o,
  output logic [PAYLOAD_BITS-1:0]         send_payload_o,
  output logic                            offer_accepted_o,
  output logic [SEQ_BITS-1:0]             window_base_o,
  output logic [SEQ_BITS-1:0]             next_seq_o
);
  import sws_pkg::*;

  localparam int SLOT_BITS = $clog2(MAX_WINDOW);

  typedef enum logic {
    ST_IDLE,
    ST_ADV
  } state_e;

  state_e                  state_q, state_d;
  logic [SEQ_BITS-1:0]     base_q, base_d;
  logic [SEQ_BITS-1:0]     next_q, next_d;
  logic [MAX_WINDOW-1:0]   marks_q, marks_d;
  kind_e                   kind_q, kind_d;
  logic [SEQ_BITS-1:0]     sseq_q, sseq_d;
  logic [PAYLOAD_BITS-1:0] spay_q, spay_d;
  logic                    acc_q, acc_d;
  logic                    done_q, done_d;

  logic [SEQ_BITS-1:0]     cnt;
  logic [SEQ_BITS-1:0]     off;
  logic                    in_win;
  logic                    room;
  logic                    accept;
  logic                    do_offer;
  logic                    do_ack;
  logic                    do_nack;
  logic [SLOT_BITS-1:0]    bslot;
  logic                    adv;

  always_comb begin
    cnt      = next_q - base_q;
    off      = ack_seq_i - base_q;
    in_win   = off < cnt;
    room     = cnt < SEQ_BITS'(eff_win_i);
    accept   = start_i && (state_q == ST_IDLE);
    do_offer = accept && (cmd_i == CMD_OFFER) && room;
    do_ack   = accept && (cmd_i == CMD_ACK) && in_win;
    do_nack  = accept && (cmd_i == CMD_NACK) && in_win;
    bslot    = base_q[SLOT_BITS-1:0];
    adv      = (base_q != next_q) && marks_q[bslot];

    ram_we_o    = do_offer;
    ram_waddr_o = next_q[SLOT_BITS-1:0];
    ram_wdata_o = payload_i;
    ram_re_o    = do_nack;
    ram_raddr_o = ack_seq_i[SLOT_BITS-1:0];

    state_d = state_q;
    base_d  = base_q;
    next_d  = next_q;
    marks_d = marks_q;
    kind_d  = kind_q;
    sseq_d  = sseq_q;
    spay_d  = spay_q;
    acc_d   = acc_q;
    done_d  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_ADV;
          kind_d  = KIND_NONE;
          sseq_d  = '0;
          spay_d  = '0;
          acc_d   = 1'b0;
          if (do_offer) begin
            marks_d[next_q[SLOT_BITS-1:0]] = 1'b0;
            kind_d = KIND_NEW;
            sseq_d = next_q;
            spay_d = payload_i;
            acc_d  = 1'b1;
            next_d = next_q + 1'b1;
          end
          if (do_ack) begin
            marks_d[ack_seq_i[SLOT_BITS-1:0]] = 1'b1;
          end
          if (do_nack) begin
            kind_d = KIND_RESEND;
            sseq_d = ack_seq_i;
          end
        end
      end
      ST_ADV: begin
        if (adv) begin
          // drop the acknowledged slot at the base and step past it
          marks_d[bslot] = 1'b0;
          base_d = base_q + 1'b1;
        end else begin
          if (kind_q == KIND_RESEND) begin
            spay_d = ram_rdata_i;
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      base_q  <= '0;
      next_q  <= '0;
      marks_q <= '0;
      kind_q  <= KIND_NONE;
      sseq_q  <= '0;
      spay_q  <= '0;
      acc_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      next_q  <= next_d;
      marks_q <= marks_d;
      kind_q  <= kind_d;
      sseq_q  <= sseq_d;
      spay_q  <= spay_d;
      acc_q   <= acc_d;
      done_q  <= done_d;
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign send_kind_o      = kind_q;
  assign send_seq_o       = sseq_q;
  assign send_payload_o   = spay_q;
  assign offer_accepted_o = acc_q;
  assign window_base_o    = base_q;
  assign next_seq_o       = next_q;

endmodule

// ===== design/sliding_window_sender.sv =====
// Top level of the selective-repeat sliding window sender.
//
// Commands enter on start_i/busy_o: a command is taken at a clock edge with
// start_i high and busy_o low. cmd_i selects offer, acknowledge or negative
// acknowledge; ack_seq_i and payload_i carry its operands.
// Every command gives exactly one result, shown for one cycle with done_o
// high; the receiver has no way to hold it off.
// The window size register is written over cfg_valid_i/cfg_ready_o/cfg_data_i,
// which is always ready; write it only while no command is in flight.
// After the edge that takes the command, the base moves past the acknowledged
// slots (0 to MAX_WINDOW of them), one slot per cycle, and then the result is
// shown. A new command can be taken at the edge that ends the result cycle.
// Resent handles come from the slot RAM, read in the cycle the command is
// taken.
// Reset sets the window size to 1, both pointers to 0 and clears every
// acknowledge mark; the slot RAM keeps its contents and needs no clearing.
module sliding_window_sender #(
  parameter int MAX_WINDOW   = sws_pkg::MAX_WINDOW_DEF,
  parameter int SEQ_BITS     = sws_pkg::SEQ_BITS_DEF,
  parameter int PAYLOAD_BITS = sws_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [sws_pkg::CMD_BITS-1:0]  cmd_i,
  input  logic [SEQ_BITS-1:0]           ack_seq_i,
  input  logic [PAYLOAD_BITS-1:0]       payload_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sws_pkg::CFG_BITS-1:0]  cfg_data_i,
  output logic                          done_o,
  output logic [sws_pkg::KIND_BITS-1:0] send_kind_o,
  output logic [SEQ_BITS-1:0]           send_seq_o,
  output logic [PAYLOAD_BITS-1:0]       send_payload_o,
  output logic                          offer_accepted_o,
  output logic [SEQ_BITS-1:0]           window_base_o,
  output logic [SEQ_BITS-1:0]           next_seq_o
);
  import sws_pkg::*;

  localparam int SLOT_BITS = $clog2(MAX_WINDOW);
  localparam int WIN_BITS  = SLOT_BITS + 1;
  localparam int CMP_BITS  = (WIN_BITS > CFG_BITS) ? WIN_BITS : CFG_BITS;

  logic [CFG_BITS-1:0]     win_cfg_q;
  logic [WIN_BITS-1:0]     eff_win;
  logic                    ram_we;
  logic [SLOT_BITS-1:0]    ram_waddr;
  logic [PAYLOAD_BITS-1:0] ram_wdata;
  logic                    ram_re;
  logic [SLOT_BITS-1:0]    ram_raddr;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      win_cfg_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // clamp the register to 1 .. MAX_WINDOW
  always_comb begin
    if (win_cfg_q == '0) begin
      eff_win = WIN_BITS'(1);
    end else if (CMP_BITS'(win_cfg_q) > CMP_BITS'(MAX_WINDOW)) begin
      eff_win = WIN_BITS'(MAX_WINDOW);
    end else begin
      eff_win = WIN_BITS'(win_cfg_q);
    end
  end

  sws_ctrl #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .ack_seq_i        (ack_seq_i),
    .payload_i        (payload_i),
    .eff_win_i        (eff_win),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .done_o           (done_o),
    .send_kind_o      (send_kind_o),
    .send_seq_o       (send_seq_o),
    .send_payload_o   (send_payload_o),
    .offer_accepted_o (offer_accepted_o),
    .window_base_o    (window_base_o),
    .next_seq_o       (next_seq_o)
  );

  sws_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== design/sws_checker.sv =====
// Port-level checks of the sliding window sender, bound to the top level.
`include "assert_macros.svh"

module sws_checker #(
  parameter int MAX_WINDOW = sws_pkg::MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = sws_pkg::SEQ_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic [sws_pkg::KIND_BITS-1:0] send_kind_o,
  input logic [SEQ_BITS-1:0]           send_seq_o,
  input logic                          offer_accepted_o,
  input logic [SEQ_BITS-1:0]           window_base_o,
  input logic [SEQ_BITS-1:0]           next_seq_o
);
  import sws_pkg::*;

  logic                accept;
  logic                new_sent;
  logic                new_ok;
  logic                within_store;
  logic [SEQ_BITS-1:0] last_seq;
  logic [SEQ_BITS-1:0] in_flight;

  assign accept       = start_i && !busy_o;
  assign new_sent     = done_o && (send_kind_o == KIND_NEW);
  assign last_seq     = next_seq_o - 1'b1;
  assign in_flight    = next_seq_o - window_base_o;
  assign new_ok       = offer_accepted_o && (send_seq_o == last_seq);
  assign within_store = in_flight <= SEQ_BITS'(MAX_WINDOW);

  `SWS_ASSERT_NEXT(a_accept_busy, accept, busy_o, "accepted transaction did not raise busy")
  `SWS_ASSERT_NOW(a_done_after_busy, done_o, $past(busy_o), "result without work in progress")
  `SWS_ASSERT_NOW(a_new_seq, new_sent, new_ok, "new packet lacks the last assigned sequence")
  `SWS_ASSERT_NOW(a_window_bound, done_o, within_store, "outstanding count exceeds the store")

endmodule

bind sliding_window_sender sws_checker #(
  .MAX_WINDOW (MAX_WINDOW),
  .SEQ_BITS   (SEQ_BITS)
) u_sws_checker (.*);
